// File: src/escc_pkg.sv
// Shared types, constants and helper functions of the early stop codon counter.
package escc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [7:0] GAP_LETTER = 8'h2D;
    localparam logic [7:0] LETTER_T   = 8'h54;
    localparam logic [7:0] LETTER_A   = 8'h41;
    localparam logic [7:0] LETTER_G   = 8'h47;

    typedef enum logic [1:0] {
        CFG_DROP_GAP  = 2'd0,
        CFG_KEEP_LAST    = 2'd1,
        CFG_REPORT_MODE  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        RPT_TOTAL = 2'd0,
        RPT_FILE  = 2'd1,
        RPT_SEQ   = 2'd2
    } t_report_mode;

    typedef enum logic [1:0] {
        KIND_TOTAL = 2'd0,
        KIND_FILE  = 2'd1,
        KIND_SEQ   = 2'd2
    } t_report_kind;

    typedef struct packed {
        logic       drop_gap;
        logic       keep_last_codon;
        logic [1:0] report_mode;
    } t_cfg;

    // Classified item: stops to add, and which ends it carries.
    typedef struct packed {
        logic [1:0] inc;
        logic       end_seq;
        logic       end_file;
        logic       end_stream;
    } t_evt;

    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_qpush;

    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_qhead;

    function automatic logic is_stop(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (a == LETTER_T) begin
            if (b == LETTER_A) begin
                hit = (c == LETTER_A) || (c == LETTER_G);
            end else begin
                hit = (b == LETTER_G) && (c == LETTER_A);
            end
        end
        return hit;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] v,
                                                       input logic [1:0] inc);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, v} + (COUNT_WIDTH+1)'(inc);
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_WIDTH-1:0] out_clamp(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'(OUT_WIDTH'('1))) ? '1 : w[OUT_WIDTH-1:0];
    endfunction

endpackage

// File: src/escc_if.sv
// Channel interfaces: symbol input, report output and register writes.
interface escc_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_in_sequence;
    logic       last_in_file;
    logic       last_in_stream;

    modport source (output valid, symbol, last_in_sequence, last_in_file, last_in_stream,
                    input ready);
    modport sink   (input valid, symbol, last_in_sequence, last_in_file, last_in_stream,
                    output ready);
endinterface

interface escc_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] stop_count;
    logic [1:0]  report_kind;

    modport source (output valid, stop_count, report_kind, input ready);
    modport sink   (input valid, stop_count, report_kind, output ready);
endinterface

interface escc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/early_stop_codon_counter.sv
// Early stop codon counter top level: register port, front end, event queue, back end.
// Throughput: one symbol per cycle; the input stalls only when the two-entry queue is full.
// Each report passes the event queue, then the output register, after its closing symbol.
// The output register frees as its report transfers, so a new report can follow each cycle.
// Reset (synchronous, active low) clears registers, codon state, counters and the queue.
module early_stop_codon_counter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    escc_sym_if.sink           i_sym,
    escc_res_if.source         o_res,
    escc_cfg_if.sink           i_cfg
);
    import escc_pkg::*;

    t_cfg   r_cfg;
    t_qpush push;
    t_qhead head;
    logic   full, pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DROP_GAP:     r_cfg.drop_gap        <= i_cfg.data[0];
                CFG_KEEP_LAST:    r_cfg.keep_last_codon <= i_cfg.data[0];
                CFG_REPORT_MODE:  r_cfg.report_mode     <= i_cfg.data;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    escc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_valid            (i_sym.valid),
        .i_symbol           (i_sym.symbol),
        .i_last_in_sequence (i_sym.last_in_sequence),
        .i_last_in_file     (i_sym.last_in_file),
        .i_last_in_stream   (i_sym.last_in_stream),
        .i_full             (full),
        .o_ready            (i_sym.ready),
        .o_push             (push)
    );

    escc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    escc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_stop_count  (o_res.stop_count),
        .o_report_kind (o_res.report_kind)
    );

endmodule

// File: src/escc_front.sv
// Front end: gap filter, codon framing and stop detection per symbol.
module escc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  escc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  logic [7:0]          i_symbol,
    input  logic                i_last_in_sequence,
    input  logic                i_last_in_file,
    input  logic                i_last_in_stream,
    input  logic                i_full,
    output logic                o_ready,
    output escc_pkg::t_qpush    o_push
);
    import escc_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic       r_pend,  n_pend;

    logic drop, end_stream, end_file, end_seq, inc_a, inc_b, accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        end_stream = i_last_in_stream;
        end_file   = i_last_in_file || end_stream;
        end_seq    = i_last_in_sequence || end_file;
        drop       = i_cfg.drop_gap && (i_symbol == GAP_LETTER);
        n_phase    = r_phase;
        n_held0    = r_held0;
        n_held1    = r_held1;
        n_pend     = r_pend;
        inc_a      = 1'b0;
        inc_b      = 1'b0;
        if (!drop) begin
            if (r_phase != 2'd2) begin
                if (r_phase == 2'd0) begin
                    n_held0 = i_symbol;
                end else begin
                    n_held1 = i_symbol;
                end
                n_phase = r_phase + 2'd1;
            end else begin
                // Codon complete: release the one before it.
                inc_a   = r_pend;
                n_pend  = is_stop(r_held0, r_held1, i_symbol);
                n_phase = 2'd0;
            end
        end
        if (end_seq) begin
            inc_b   = n_pend && ((n_phase != 2'd0) || i_cfg.keep_last_codon);
            n_pend  = 1'b0;
            n_phase = 2'd0;
            n_held0 = '0;
            n_held1 = '0;
        end
        o_push.valid          = accept;
        o_push.evt.inc        = {1'b0, inc_a} + {1'b0, inc_b};
        o_push.evt.end_seq    = end_seq;
        o_push.evt.end_file   = end_file;
        o_push.evt.end_stream = end_stream;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_pend  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: src/escc_queue.sv
// Short event queue between the front end and the counting back end.
module escc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  escc_pkg::t_qpush  i_push,
    output logic              o_full,
    output escc_pkg::t_qhead  o_head,
    input  logic              i_pop
);
    import escc_pkg::*;

    t_evt              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.evt   = r_mem[r_rptr];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with unequal pointers");

endmodule

// File: src/escc_back.sv
// Back end: sequence, file and total counters and the report output register.
module escc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  escc_pkg::t_cfg    i_cfg,
    input  escc_pkg::t_qhead  i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_stop_count,
    output logic [1:0]        o_report_kind
);
    import escc_pkg::*;

    logic [COUNT_WIDTH-1:0] r_seq, r_file, r_total;
    logic [COUNT_WIDTH-1:0] seq_new, file_new, total_new;
    logic                   r_out_valid;
    logic [OUT_WIDTH-1:0]   r_out_count;
    logic [1:0]             r_out_kind;
    logic                   has_res;
    logic [OUT_WIDTH-1:0]   res_count;
    logic [1:0]             res_kind;

    assign o_pop         = i_head.valid && (!r_out_valid || i_ready);
    assign o_valid       = r_out_valid;
    assign o_stop_count  = r_out_count;
    assign o_report_kind = r_out_kind;

    always_comb begin
        seq_new   = sat_add(r_seq, i_head.evt.inc);
        file_new  = sat_add(r_file, i_head.evt.inc);
        total_new = sat_add(r_total, i_head.evt.inc);
        has_res   = 1'b0;
        res_count = out_clamp(total_new);
        res_kind  = KIND_TOTAL;
        if (i_head.evt.end_seq && (i_cfg.report_mode == RPT_SEQ) && (seq_new != '0)) begin
            has_res   = 1'b1;
            res_count = out_clamp(seq_new);
            res_kind  = KIND_SEQ;
        end
        if (i_head.evt.end_file && (i_cfg.report_mode == RPT_FILE) && (file_new != '0)) begin
            has_res   = 1'b1;
            res_count = out_clamp(file_new);
            res_kind  = KIND_FILE;
        end
        if (i_head.evt.end_stream && (i_cfg.report_mode == RPT_TOTAL)) begin
            has_res   = 1'b1;
            res_count = out_clamp(total_new);
            res_kind  = KIND_TOTAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= '0;
            r_file      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_seq       <= i_head.evt.end_seq    ? '0 : seq_new;
                r_file      <= i_head.evt.end_file   ? '0 : file_new;
                r_total     <= i_head.evt.end_stream ? '0 : total_new;
                r_out_valid <= has_res;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && has_res) begin
            r_out_count <= res_count;
            r_out_kind  <= res_kind;
        end
    end

    a_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.evt.end_seq) |=> (r_seq == '0))
        else $error("sequence count not cleared at sequence end");

    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.evt.end_stream) |=> (r_total == '0) && (r_file == '0))
        else $error("counts not cleared at stream end");

    a_kind_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && has_res) |=> (r_out_kind == $past(i_cfg.report_mode)))
        else $error("report kind does not follow report mode");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the early stop codon counter: directed cases, then random streams.
module tb_top;
    import escc_pkg::*;

    localparam int         QUIET_LIMIT      = 2000;
    localparam int         DRAIN_CYCLES     = 8;
    localparam int         PHASES           = 11;
    localparam int         PHASE_SYMBOLS    = 115;
    localparam logic [7:0] LETTER_C         = 8'h43;
    localparam logic [1:0] UNUSED_CFG_INDEX = 2'd3;

    localparam logic [7:0]  BASES [4]         = '{LETTER_T, LETTER_A, LETTER_G, LETTER_C};
    localparam logic [23:0] STOP_TRIPLETS [3] = '{"TAA", "TAG", "TGA"};

    typedef struct packed {
        logic [31:0]  stops;
        t_report_kind kind;
    } t_stop_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    escc_sym_if sym_ch ();
    escc_res_if rpt_ch ();
    escc_cfg_if reg_ch ();

    early_stop_codon_counter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_ch),
        .o_res   (rpt_ch),
        .i_cfg   (reg_ch)
    );

    always #2 i_clk = ~i_clk;

    // Predicted block state and settings
    logic                   cfg_drop_gaps = 1'b0;
    logic                   cfg_keep_last = 1'b0;
    logic [1:0]             cfg_mode      = 2'd0;
    logic [1:0]             frame_pos     = 2'd0;
    logic [7:0]             open_codon [2] = '{8'd0, 8'd0};
    logic                   stop_waiting  = 1'b0;
    logic [COUNT_WIDTH-1:0] seq_stops     = '0;
    logic [COUNT_WIDTH-1:0] file_stops    = '0;
    logic [COUNT_WIDTH-1:0] stream_stops  = '0;

    t_stop_report awaited_reports [$];

    int  mismatches    = 0;
    int  symbols_sent  = 0;
    int  sym_gap       = 0;
    bit  tx_idle       = 1'b0;
    bit  rx_idle       = 1'b0;
    int  quiet_cycles  = 0;

    function automatic logic stop_triplet(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        return (a == LETTER_T) &&
               (((b == LETTER_A) && ((c == LETTER_A) || (c == LETTER_G))) ||
                ((b == LETTER_G) && (c == LETTER_A)));
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [31:0] clamp_report(input logic [COUNT_WIDTH-1:0] v);
        return (64'(v) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    function void record_stop();
        seq_stops    = bump(seq_stops);
        file_stops   = bump(file_stops);
        stream_stops = bump(stream_stops);
    endfunction

    function void track_symbol(input logic [7:0] s, input logic ls, input logic lf,
                               input logic lst);
        logic end_file;
        logic end_seq;
        logic hit;
        end_file = lf || lst;
        end_seq  = ls || end_file;
        if (!(cfg_drop_gaps && s == GAP_LETTER)) begin
            if (frame_pos < 2) begin
                open_codon[frame_pos[0]] = s;
                frame_pos++;
            end else begin
                // the codon before this one is now known not to be the last
                hit = stop_triplet(open_codon[0], open_codon[1], s);
                if (stop_waiting) record_stop();
                stop_waiting = hit;
                frame_pos    = 2'd0;
            end
        end
        if (end_seq) begin
            if (stop_waiting && (frame_pos != 0 || cfg_keep_last)) record_stop();
            stop_waiting = 1'b0;
            frame_pos    = 2'd0;
            open_codon   = '{8'd0, 8'd0};
            if (cfg_mode == RPT_SEQ && seq_stops != 0)
                awaited_reports.push_back('{clamp_report(seq_stops), KIND_SEQ});
            seq_stops = '0;
        end
        if (end_file) begin
            if (cfg_mode == RPT_FILE && file_stops != 0)
                awaited_reports.push_back('{clamp_report(file_stops), KIND_FILE});
            file_stops = '0;
        end
        if (lst) begin
            if (cfg_mode == RPT_TOTAL)
                awaited_reports.push_back('{clamp_report(stream_stops), KIND_TOTAL});
            stream_stops = '0;
        end
    endfunction

    function automatic int draw_wait(input bit idle_on);
        return idle_on ? int'($urandom_range(0, 17)) : 0;
    endfunction

    // Keep valid high across back-to-back transfers; lower it only ahead of a gap.
    task automatic send_symbol(input logic [7:0] s, input logic ls, input logic lf,
                               input logic lst);
        repeat (sym_gap) @(posedge i_clk);
        sym_ch.valid            <= 1'b1;
        sym_ch.symbol           <= s;
        sym_ch.last_in_sequence <= ls;
        sym_ch.last_in_file     <= lf;
        sym_ch.last_in_stream   <= lst;
        @(posedge i_clk);
        while (!sym_ch.ready) @(posedge i_clk);
        track_symbol(s, ls, lf, lst);
        symbols_sent++;
        if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
        sym_gap = draw_wait(tx_idle);
        if (sym_gap > 0) sym_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        if (sym_gap == 0) sym_ch.valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        // hold off for items still in flight that give no report
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic drop_gaps, input logic keep_last,
                                 input logic [1:0] mode, input bit poke_unused);
        logic [1:0] addr   [4];
        logic [1:0] values [4];
        int         n_writes;
        addr   = '{CFG_DROP_GAP, CFG_KEEP_LAST, CFG_REPORT_MODE, UNUSED_CFG_INDEX};
        values = '{{1'($urandom_range(0, 1)), drop_gaps}, {1'($urandom_range(0, 1)), keep_last},
                   mode, 2'($urandom_range(0, 3))};
        n_writes = poke_unused ? 4 : 3;
        for (int i = 0; i < n_writes; i++) begin
            reg_ch.valid <= 1'b1;
            reg_ch.index <= addr[i];
            reg_ch.data  <= values[i];
            @(posedge i_clk);
            while (!reg_ch.ready) @(posedge i_clk);
        end
        reg_ch.valid <= 1'b0;
        cfg_drop_gaps = drop_gaps;
        cfg_keep_last = keep_last;
        cfg_mode      = mode;
    endtask

    task automatic send_letters(input logic [47:0] text, input int n, input logic ls,
                                input logic lf, input logic lst);
        for (int k = 0; k < n; k++) begin
            if (k == n - 1) send_symbol(text[8*(n-1-k) +: 8], ls, lf, lst);
            else send_symbol(text[8*(n-1-k) +: 8], 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Final full codon dropped, then a trailing partial codon lets the last stop count.
    task automatic test_sequence_report();
        load_settings(1'b0, 1'b0, RPT_SEQ, 1'b0);
        send_letters("TAATGA", 6, 1'b1, 1'b0, 1'b0);
        send_letters("TAGC", 4, 1'b1, 1'b0, 1'b0);
        wait_drained();
    endtask

    // Dropped gaps, kept last codon, file end implying sequence end, gap carrying the marks.
    task automatic test_file_report_gaps();
        load_settings(1'b1, 1'b1, RPT_FILE, 1'b0);
        send_letters("T-GA", 4, 1'b0, 1'b1, 1'b0);
        send_symbol(GAP_LETTER, 1'b0, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Extreme bytes and a zero total at stream end.
    task automatic test_stream_total();
        load_settings(1'b0, 1'b0, RPT_TOTAL, 1'b0);
        send_symbol(8'hFF, 1'b1, 1'b0, 1'b0);
        send_symbol(8'h00, 1'b1, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic send_random_sequence();
        int         n_letters;
        int         end_kind;
        int         stop_pick;
        bit         noisy;
        bit         gap_tail;
        logic       ls;
        logic       lf;
        logic       lst;
        logic [7:0] codon [3];
        logic [7:0] letter;
        noisy     = ($urandom_range(0, 4) == 0);
        gap_tail  = ($urandom_range(0, 9) == 0);
        n_letters = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
        end_kind  = $urandom_range(0, 5);
        lst = (end_kind == 0);
        lf  = lst ? 1'($urandom_range(0, 1)) : (end_kind <= 2);
        ls  = (end_kind <= 2) ? 1'($urandom_range(0, 1)) : 1'b1;
        for (int k = 0; k < n_letters; k++) begin
            if (k % 3 == 0) begin
                stop_pick = $urandom_range(0, 4);
                for (int j = 0; j < 3; j++) begin
                    if (noisy && $urandom_range(0, 1))
                        codon[j] = 8'($urandom_range(0, 255));
                    else if (!noisy && stop_pick < 3)
                        codon[j] = STOP_TRIPLETS[stop_pick][8*(2-j) +: 8];
                    else
                        codon[j] = BASES[$urandom_range(0, 3)];
                end
            end
            letter = codon[k % 3];
            if ($urandom_range(0, 11) == 0) send_symbol(GAP_LETTER, 1'b0, 1'b0, 1'b0);
            if (k == n_letters - 1 && !gap_tail) send_symbol(letter, ls, lf, lst);
            else send_symbol(letter, 1'b0, 1'b0, 1'b0);
        end
        if (gap_tail) send_symbol(GAP_LETTER, ls, lf, lst);
    endtask

    // Cycle through every report mode, the unused one included, with random gap/keep flags.
    task automatic test_random_streams();
        int phase_start;
        for (int p = 0; p < PHASES; p++) begin
            load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'(p % 4),
                          p == 0);
            phase_start = symbols_sent;
            while (symbols_sent - phase_start < PHASE_SYMBOLS) send_random_sequence();
            wait_drained();
        end
    endtask

    // Report sink: after each transfer, ready may drop for a randomly drawn stall
    initial begin : report_sink
        int stall;
        stall = 0;
        rpt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rpt_ch.valid && rpt_ch.ready) begin
                if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
                stall = draw_wait(rx_idle);
            end else if (stall > 0) begin
                stall--;
            end
            rpt_ch.ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        t_stop_report want;
        if (i_rst_n && rpt_ch.valid && rpt_ch.ready) begin
            if (awaited_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected report, expected none, got stop_count %0d kind %0d",
                         $time, rpt_ch.stop_count, rpt_ch.report_kind);
            end else begin
                want = awaited_reports.pop_front();
                if (rpt_ch.stop_count !== want.stops) begin
                    mismatches++;
                    $display("%0t: stop_count expected %0d, got %0d",
                             $time, want.stops, rpt_ch.stop_count);
                end
                if (rpt_ch.report_kind !== want.kind) begin
                    mismatches++;
                    $display("%0t: report_kind expected %0d, got %0d",
                             $time, want.kind, rpt_ch.report_kind);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((sym_ch.valid && sym_ch.ready) || (rpt_ch.valid && rpt_ch.ready) ||
            (reg_ch.valid && reg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n                 <= 1'b0;
        sym_ch.valid            <= 1'b0;
        sym_ch.symbol           <= 8'd0;
        sym_ch.last_in_sequence <= 1'b0;
        sym_ch.last_in_file     <= 1'b0;
        sym_ch.last_in_stream   <= 1'b0;
        reg_ch.valid            <= 1'b0;
        reg_ch.index            <= CFG_DROP_GAP;
        reg_ch.data             <= 2'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_sequence_report();
        test_file_report_gaps();
        test_stream_total();
        test_random_streams();
        wait_drained();
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
